### src/rvd_pkg.sv
package rvd_pkg;

	localparam int WINDOW_DEFAULT = 128;
	localparam int PRICE_W        = 24;
	localparam int PCT_W          = 16;
	localparam int SCALE_W        = 15;

	localparam logic [PCT_W-1:0]   PCT_MAX      = 16'hFFFF;
	localparam logic [PCT_W-1:0]   THRESH_RESET = 16'd640;
	localparam logic [SCALE_W-1:0] SCALE_PCT    = 15'd25600;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQ,
		S_SUM,
		S_PROD,
		S_COMB,
		S_DIFF,
		S_SQRT,
		S_SCALE,
		S_DIVCHK,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic sq;
		logic upd;
		logic prod;
		logic comb;
		logic diff;
		logic sqrt_step;
		logic scale;
		logic divchk;
		logic div_step;
		logic res_zero;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic zero_case;
		logic ovf;
		logic last;
	} sts_t;

endpackage

### src/rvd_ctrl.sv
module rvd_ctrl
	import rvd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nx;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_nx = S_SQ;
			S_SQ:     state_nx = S_SUM;
			S_SUM:    state_nx = S_PROD;
			S_PROD:   state_nx = sts.zero_case ? S_DONE : S_COMB;
			S_COMB:   state_nx = S_DIFF;
			S_DIFF:   state_nx = S_SQRT;
			S_SQRT:   if (sts.last) state_nx = S_SCALE;
			S_SCALE:  state_nx = S_DIVCHK;
			S_DIVCHK: state_nx = sts.ovf ? S_DONE : S_DIV;
			S_DIV:    if (sts.last) state_nx = S_DONE;
			S_DONE:   if (out_free) state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.accept    = in_valid;
			S_SQ:     cmd.sq        = 1'b1;
			S_SUM:    cmd.upd       = 1'b1;
			S_PROD: begin
				cmd.prod     = 1'b1;
				cmd.res_zero = sts.zero_case;
			end
			S_COMB:   cmd.comb      = 1'b1;
			S_DIFF:   cmd.diff      = 1'b1;
			S_SQRT:   cmd.sqrt_step = 1'b1;
			S_SCALE:  cmd.scale     = 1'b1;
			S_DIVCHK: cmd.divchk    = 1'b1;
			S_DIV:    cmd.div_step  = 1'b1;
			S_DONE:   cmd.load_out  = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

### src/rvd_datapath.sv
module rvd_datapath
	import rvd_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [PRICE_W-1:0] price,
	input  logic               cfg_wr_en,
	input  logic [PCT_W-1:0]   cfg_wr_data,
	input  cmd_t               cmd,
	output sts_t               sts,
	output logic [PCT_W-1:0]   volatility_pct,
	output logic               high_vol
);

	localparam int LW = $clog2(WINDOW);
	localparam int AW = (LW < 1) ? 1 : LW;
	localparam int SW = LW + PRICE_W;
	localparam int QW = LW + 2 * PRICE_W;
	localparam int DW = 2 * SW;
	localparam int RW = SW;
	localparam int NW = RW + SCALE_W;
	localparam int CW = $clog2(RW);
	localparam int H  = (SW + 1) / 2;
	localparam int HW = SW - H;

	logic [PRICE_W-1:0] mem [WINDOW];
	logic [PRICE_W-1:0] rd_q, price_q, old_q, old_val;
	logic [2*PRICE_W-1:0] old_sq_q, new_sq_q;

	logic [AW-1:0] slot_q;
	logic [1:0]    seen_q;
	logic          wrapped_q;
	logic [SW-1:0] sum_q;
	logic [QW-1:0] sumsq_q;

	logic [2*HW-1:0] pp_hh_q;
	logic [SW-1:0]   pp_hl_q;
	logic [2*H-1:0]  pp_ll_q;
	logic [DW-1:0]   wsq_q, sq_q;

	logic [DW-1:0]   rad_q;
	logic [RW-1:0]   rem_q, root_q;
	logic [RW+1:0]   rem_sh, trial;
	logic            rem_ge;

	logic [NW-1:0]   num_q;
	logic [SW-1:0]   drem_q;
	logic [PCT_W-1:0] dnum_q, res_q, thresh_q;
	logic [SW:0]     dtry;
	logic            dge;
	logic [CW-1:0]   cnt_q;

	logic [PCT_W-1:0] pct_q;
	logic             high_q;

	// Slots not yet written since reset read as zero.
	assign old_val = wrapped_q ? rd_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_q    <= mem[slot_q];
			price_q <= price;
		end
		if (cmd.sq) begin
			mem[slot_q] <= price_q;
			old_q       <= old_val;
			old_sq_q    <= (2*PRICE_W)'(old_val) * (2*PRICE_W)'(old_val);
			new_sq_q    <= (2*PRICE_W)'(price_q) * (2*PRICE_W)'(price_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			seen_q    <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
			sumsq_q   <= '0;
			thresh_q  <= THRESH_RESET;
		end else begin
			if (cfg_wr_en) begin
				thresh_q <= cfg_wr_data;
			end
			if (cmd.upd) begin
				sum_q   <= sum_q - SW'(old_q) + SW'(price_q);
				sumsq_q <= sumsq_q - QW'(old_sq_q) + QW'(new_sq_q);
				if (seen_q != 2'd2) begin
					seen_q <= seen_q + 2'd1;
				end
				if (slot_q == AW'(WINDOW - 1)) begin
					slot_q    <= '0;
					wrapped_q <= 1'b1;
				end else begin
					slot_q <= slot_q + AW'(1);
				end
			end
		end
	end

	// Root digit: bring down two radicand bits, try (root*4 + 1).
	assign rem_sh = {rem_q, rad_q[DW-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign rem_ge = (rem_sh >= trial);

	// Quotient digit: bring down one numerator bit, try the window sum.
	assign dtry = {drem_q, dnum_q[PCT_W-1]};
	assign dge  = (dtry >= {1'b0, sum_q});

	always_ff @(posedge clk) begin
		if (cmd.prod) begin
			pp_hh_q <= (2*HW)'(sum_q[SW-1:H]) * (2*HW)'(sum_q[SW-1:H]);
			pp_hl_q <= SW'(sum_q[SW-1:H]) * SW'(sum_q[H-1:0]);
			pp_ll_q <= (2*H)'(sum_q[H-1:0]) * (2*H)'(sum_q[H-1:0]);
			wsq_q   <= DW'(sumsq_q) * DW'(WINDOW);
		end
		if (cmd.res_zero) begin
			res_q <= '0;
		end
		if (cmd.comb) begin
			sq_q <= (DW'(pp_hh_q) << (2 * H)) + (DW'(pp_hl_q) << (H + 1)) + DW'(pp_ll_q);
		end
		if (cmd.diff) begin
			rad_q  <= (wsq_q >= sq_q) ? wsq_q - sq_q : '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= CW'(RW - 1);
		end
		if (cmd.sqrt_step) begin
			rad_q  <= rad_q << 2;
			rem_q  <= rem_ge ? RW'(rem_sh - trial) : RW'(rem_sh);
			root_q <= {root_q[RW-2:0], rem_ge};
			cnt_q  <= cnt_q - CW'(1);
		end
		if (cmd.scale) begin
			num_q <= NW'(root_q) * NW'(SCALE_PCT);
		end
		if (cmd.divchk) begin
			if (sts.ovf) begin
				res_q <= PCT_MAX;
			end
			drem_q <= SW'(num_q[NW-1:PCT_W]);
			dnum_q <= num_q[PCT_W-1:0];
			cnt_q  <= CW'(PCT_W - 1);
		end
		if (cmd.div_step) begin
			drem_q <= dge ? SW'(dtry - {1'b0, sum_q}) : dtry[SW-1:0];
			dnum_q <= dnum_q << 1;
			res_q  <= {res_q[PCT_W-2:0], dge};
			cnt_q  <= cnt_q - CW'(1);
		end
		if (cmd.load_out) begin
			pct_q  <= res_q;
			high_q <= (res_q > thresh_q);
		end
	end

	assign sts.zero_case = (seen_q != 2'd2) || (sum_q == '0);
	assign sts.ovf       = ((NW+1)'(num_q) >= ((NW+1)'(sum_q) << PCT_W));
	assign sts.last      = (cnt_q == '0);

	assign volatility_pct = pct_q;
	assign high_vol       = high_q;

endmodule

### src/rolling_volatility_detector_top.sv
// Rolling-window volatility detector.
// Input channel: in_valid / in_stall with one unsigned Q16.8 price per item.
// Output channel: out_valid / out_stall with volatility_pct (Q8.8 percent,
// std deviation over mean, saturating at 65535) and high_vol, set when
// volatility_pct exceeds the threshold written on cfg_wr_en / cfg_wr_data.
// One result per item. Let SW = clog2(WINDOW) + 24 (31 at WINDOW = 128).
// A full result passes the sum update, the root unit (one result bit per cycle,
// SW steps) and the 16-step quotient unit before it is registered; in_stall
// holds off the next item until the result has been loaded. Before the second
// sample or with a zero window sum the result is 0 and the root and quotient
// steps are skipped; a saturated quotient skips the 16 quotient steps.
// Reset empties the window (unwritten slots read as zero), clears the sums
// and sets the threshold to 2.5 percent; items are taken right after reset.
// A stalled result holds in the output register while the next item is
// already being worked on; that item then waits until the register frees.
module rolling_volatility_detector_top
	import rvd_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [PRICE_W-1:0] price,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PCT_W-1:0]   volatility_pct,
	output logic               high_vol,
	input  logic               cfg_wr_en,
	input  logic [PCT_W-1:0]   cfg_wr_data
);

	cmd_t cmd;
	sts_t sts;

	// Sequence the item through update, root and quotient steps.
	rvd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold the window, running sums, arithmetic units and result register.
	rvd_datapath #(
		.WINDOW (WINDOW)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.price          (price),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.cmd            (cmd),
		.sts            (sts),
		.volatility_pct (volatility_pct),
		.high_vol       (high_vol)
	);

endmodule
